@@ rtl/spherical_warp_coordinate_map_unit_defines.svh @@
// ----------------------------------------------------------------------------
// spherical warp coordinate map - assertion macros
// clocked on i_clk, disabled while i_rst_n is low
// ----------------------------------------------------------------------------
`ifndef SPHERICAL_WARP_COORDINATE_MAP_UNIT_DEFINES_SVH
`define SPHERICAL_WARP_COORDINATE_MAP_UNIT_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define SWCM_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define SWCM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/swcm_pkg.sv @@
// ----------------------------------------------------------------------------
// swcm_pkg
// shared widths, constants, register codes and lane types of the warp unit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package swcm_pkg;

    localparam int COORD_BITS_DEF    = 12;
    localparam int CORDIC_STAGES_DEF = 16;
    localparam int ATAN_LEN          = 24;

    localparam int PIX_W      = 12;
    localparam int CFG_W      = 13;
    localparam int FOCAL_W    = 16;
    localparam int ROW_W      = 48;
    localparam int COEF_W     = 16;
    localparam int OUT_W      = 20;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 48;

    // phase divider
    localparam int NUM_W   = 16;
    localparam int DEN_W   = 15;
    localparam int PHASE_W = 32;
    localparam int DVD_W   = NUM_W + PHASE_W;

    // cordic, Q30
    localparam int CORDIC_W = 34;
    localparam int FRAC     = 30;
    localparam logic [31:0] CORDIC_GAIN = 32'h26DD3B6A;

    localparam logic [31:0] ATAN_TURNS [ATAN_LEN] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    // rotation and projection
    localparam int PROD_W = COEF_W + CORDIC_W;
    localparam int SUM_W  = PROD_W + 2;
    localparam int Z_W    = SUM_W;
    localparam int REM_W  = Z_W + FOCAL_W + 1;
    localparam int Q_BITS = 23;
    localparam int PR_W   = Z_W + Q_BITS;
    localparam int VAL_W  = 25;

    localparam int EPS_Q44   = 1759;
    localparam int QUOT_CLIP = 2097152;
    localparam int OUT_MAX   = 524287;
    localparam int OUT_MIN   = -524288;

    // register codes
    localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DST_HEIGHT = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FOCAL      = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ROT_ROW0   = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ROT_ROW1   = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_ROT_ROW2   = 4'd7;

    localparam logic [CFG_W-1:0]   RST_DST_WIDTH  = 13'd1024;
    localparam logic [CFG_W-1:0]   RST_DST_HEIGHT = 13'd512;
    localparam logic [CFG_W-1:0]   RST_SRC_WIDTH  = 13'd640;
    localparam logic [CFG_W-1:0]   RST_SRC_HEIGHT = 13'd480;
    localparam logic [FOCAL_W-1:0] RST_FOCAL      = 16'd8000;
    localparam logic [ROW_W-1:0]   RST_ROT_ROW0   = 48'h0000_0000_4000;
    localparam logic [ROW_W-1:0]   RST_ROT_ROW1   = 48'h0000_4000_0000;
    localparam logic [ROW_W-1:0]   RST_ROT_ROW2   = 48'h4000_0000_0000;

    typedef struct packed {
        logic [DEN_W-1:0]   rem;
        logic [DVD_W-1:0]   dvd;
        logic [PHASE_W-1:0] quo;
    } t_div_lane;

    typedef struct packed {
        logic signed [CORDIC_W-1:0] x;
        logic signed [CORDIC_W-1:0] y;
        logic signed [CORDIC_W-1:0] z;
        logic                       flip;
    } t_cordic_lane;

    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [Z_W-1:0]    z;
        logic [Q_BITS-1:0] q;
        logic              ovf;
        logic              neg;
        logic              behind;
    } t_proj_lane;

endpackage

@@ rtl/swcm_div_cell.sv @@
// ----------------------------------------------------------------------------
// swcm_div_cell
// one restoring division step of the phase divider, one quotient bit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module swcm_div_cell (
    input  logic                            i_clk,
    input  logic                            i_en,
    input  logic [swcm_pkg::DEN_W-1:0]      i_den,
    input  swcm_pkg::t_div_lane             i_lane,
    output swcm_pkg::t_div_lane             o_lane
);
    import swcm_pkg::*;

    t_div_lane        r_lane;
    t_div_lane        n_lane;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;

    assign trial = {i_lane.rem, i_lane.dvd[DVD_W-1]};
    assign diff  = trial - {1'b0, i_den};

    always_comb begin
        n_lane.dvd = {i_lane.dvd[DVD_W-2:0], 1'b0};
        if (trial >= {1'b0, i_den}) begin
            n_lane.rem = diff[DEN_W-1:0];
            n_lane.quo = {i_lane.quo[PHASE_W-2:0], 1'b1};
        end else begin
            n_lane.rem = trial[DEN_W-1:0];
            n_lane.quo = {i_lane.quo[PHASE_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lane <= n_lane;
        end
    end

    assign o_lane = r_lane;

endmodule

@@ rtl/swcm_cordic_cell.sv @@
// ----------------------------------------------------------------------------
// swcm_cordic_cell
// one rotation-mode cordic micro-rotation with a fixed shift
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module swcm_cordic_cell #(
    parameter int STAGE = 0
) (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  swcm_pkg::t_cordic_lane  i_lane,
    output swcm_pkg::t_cordic_lane  o_lane
);
    import swcm_pkg::*;

    localparam logic signed [CORDIC_W-1:0] ANGLE =
        $signed({{(CORDIC_W-32){1'b0}}, ATAN_TURNS[STAGE]});

    t_cordic_lane               r_lane;
    t_cordic_lane               n_lane;
    logic signed [CORDIC_W-1:0] dx;
    logic signed [CORDIC_W-1:0] dy;

    assign dx = i_lane.y >>> STAGE;
    assign dy = i_lane.x >>> STAGE;

    always_comb begin
        n_lane.flip = i_lane.flip;
        if (!i_lane.z[CORDIC_W-1]) begin
            n_lane.x = i_lane.x - dx;
            n_lane.y = i_lane.y + dy;
            n_lane.z = i_lane.z - ANGLE;
        end else begin
            n_lane.x = i_lane.x + dx;
            n_lane.y = i_lane.y - dy;
            n_lane.z = i_lane.z + ANGLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lane <= n_lane;
        end
    end

    assign o_lane = r_lane;

endmodule

@@ rtl/swcm_proj_cell.sv @@
// ----------------------------------------------------------------------------
// swcm_proj_cell
// one restoring step of the projection divider, quotient bit BIT
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module swcm_proj_cell #(
    parameter int BIT = 0
) (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  swcm_pkg::t_proj_lane  i_lane,
    output swcm_pkg::t_proj_lane  o_lane
);
    import swcm_pkg::*;

    t_proj_lane       r_lane;
    t_proj_lane       n_lane;
    logic [PR_W-1:0]  rem_ext;
    logic [PR_W-1:0]  divisor;
    logic [PR_W-1:0]  diff;

    assign rem_ext = PR_W'(i_lane.rem);
    assign divisor = PR_W'(i_lane.z) << BIT;
    assign diff    = rem_ext - divisor;

    always_comb begin
        n_lane = i_lane;
        if (rem_ext >= divisor) begin
            n_lane.rem = diff[REM_W-1:0];
            n_lane.q   = {i_lane.q[Q_BITS-2:0], 1'b1};
        end else begin
            n_lane.q   = {i_lane.q[Q_BITS-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lane <= n_lane;
        end
    end

    assign o_lane = r_lane;

endmodule

@@ rtl/spherical_warp_coordinate_map_unit.sv @@
// ----------------------------------------------------------------------------
// spherical_warp_coordinate_map_unit
// throughput: one request per cycle, fully pipelined, the whole pipe holds on output stall
// the pipe is the input register, the 48-cell phase divider, the cordic cell row,
// seven arithmetic stages, the 23-cell projection divider and the output register
// reset: clears every valid bit and loads the identity rotation and default sizes
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "spherical_warp_coordinate_map_unit_defines.svh"

module spherical_warp_coordinate_map_unit #(
    parameter int COORD_BITS    = swcm_pkg::COORD_BITS_DEF,
    parameter int CORDIC_STAGES = swcm_pkg::CORDIC_STAGES_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // request channel
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic [swcm_pkg::PIX_W-1:0]             i_pix_x,
    input  logic [swcm_pkg::PIX_W-1:0]             i_pix_y,
    // result channel
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic signed [swcm_pkg::OUT_W-1:0]      o_src_u,
    output logic signed [swcm_pkg::OUT_W-1:0]      o_src_v,
    output logic                                   o_behind,
    // configuration write channel
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [swcm_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [swcm_pkg::CFG_DATA_W-1:0]        i_cfg_data
);
    import swcm_pkg::*;

    localparam int LAT = 1 + DVD_W + CORDIC_STAGES + 7 + Q_BITS + 1;
    localparam logic [NUM_W-1:0] CMASK = NUM_W'((1 << COORD_BITS) - 1);
    localparam logic signed [VAL_W-1:0] V_MAX = VAL_W'(OUT_MAX);
    localparam logic signed [VAL_W-1:0] V_MIN = VAL_W'(OUT_MIN);
    localparam logic signed [SUM_W-1:0] EPS_S = SUM_W'(EPS_Q44);

    // ------------------------------------------------------------------
    // configuration registers; write only while the pipe is empty (the block does not enforce it)
    // ------------------------------------------------------------------
    logic [CFG_W-1:0]   r_dst_width;
    logic [CFG_W-1:0]   r_dst_height;
    logic [CFG_W-1:0]   r_src_width;
    logic [CFG_W-1:0]   r_src_height;
    logic [FOCAL_W-1:0] r_focal;
    logic [ROW_W-1:0]   r_rot [3];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dst_width  <= RST_DST_WIDTH;
            r_dst_height <= RST_DST_HEIGHT;
            r_src_width  <= RST_SRC_WIDTH;
            r_src_height <= RST_SRC_HEIGHT;
            r_focal      <= RST_FOCAL;
            r_rot[0]     <= RST_ROT_ROW0;
            r_rot[1]     <= RST_ROT_ROW1;
            r_rot[2]     <= RST_ROT_ROW2;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_DST_WIDTH:  r_dst_width  <= i_cfg_data[CFG_W-1:0];
                REG_DST_HEIGHT: r_dst_height <= i_cfg_data[CFG_W-1:0];
                REG_SRC_WIDTH:  r_src_width  <= i_cfg_data[CFG_W-1:0];
                REG_SRC_HEIGHT: r_src_height <= i_cfg_data[CFG_W-1:0];
                REG_FOCAL:      r_focal      <= i_cfg_data[FOCAL_W-1:0];
                REG_ROT_ROW0:   r_rot[0]     <= i_cfg_data[ROW_W-1:0];
                REG_ROT_ROW1:   r_rot[1]     <= i_cfg_data[ROW_W-1:0];
                REG_ROT_ROW2:   r_rot[2]     <= i_cfg_data[ROW_W-1:0];
                default: ;  // unknown index is ignored
            endcase
        end
    end

    // ------------------------------------------------------------------
    // pipe control: one enable for every stage, valid bits ride alongside
    // ------------------------------------------------------------------
    logic           en;
    logic [LAT-1:0] r_vld;

    assign en      = !(r_vld[LAT-1] && i_stall);
    assign o_stall = !en;
    assign o_valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    // ------------------------------------------------------------------
    // stage a: dividends and divisors of both phases
    // theta = (2x + W) / 2W turn, phi = (2y + 3H) / 4H turn, half up
    // ------------------------------------------------------------------
    logic [CFG_W-1:0] w_eff;
    logic [CFG_W-1:0] h_eff;
    logic [NUM_W-1:0] x_m;
    logic [NUM_W-1:0] y_m;
    logic [NUM_W-1:0] num_t;
    logic [NUM_W-1:0] num_p;
    logic [DEN_W-1:0] den_t;
    logic [DEN_W-1:0] den_p;
    t_div_lane        r_a_t;
    t_div_lane        r_a_p;

    assign w_eff = (r_dst_width  == '0) ? CFG_W'(1) : r_dst_width;
    assign h_eff = (r_dst_height == '0) ? CFG_W'(1) : r_dst_height;
    assign x_m   = NUM_W'(i_pix_x) & CMASK;
    assign y_m   = NUM_W'(i_pix_y) & CMASK;
    assign num_t = (x_m << 1) + NUM_W'(w_eff);
    assign num_p = (y_m << 1) + NUM_W'(h_eff) + NUM_W'({h_eff, 1'b0});
    assign den_t = DEN_W'({w_eff, 1'b0});
    assign den_p = DEN_W'({h_eff, 2'b00});

    always_ff @(posedge i_clk) begin
        if (en) begin
            // rounding half comes in as the low dividend word
            r_a_t <= '{rem: '0, dvd: {num_t, PHASE_W'(den_t >> 1)}, quo: '0};
            r_a_p <= '{rem: '0, dvd: {num_p, PHASE_W'(den_p >> 1)}, quo: '0};
        end
    end

    // ------------------------------------------------------------------
    // phase dividers: one quotient bit per cell, low word kept
    // ------------------------------------------------------------------
    t_div_lane w_div_t [DVD_W+1];
    t_div_lane w_div_p [DVD_W+1];

    assign w_div_t[0] = r_a_t;
    assign w_div_p[0] = r_a_p;

    for (genvar k = 0; k < DVD_W; k++) begin : g_div
        swcm_div_cell u_div_t (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_den  (den_t),
            .i_lane (w_div_t[k]),
            .o_lane (w_div_t[k+1])
        );
        swcm_div_cell u_div_p (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_den  (den_p),
            .i_lane (w_div_p[k]),
            .o_lane (w_div_p[k+1])
        );
    end

    // ------------------------------------------------------------------
    // fold phase into a quarter turn around zero and start the cordic
    // ------------------------------------------------------------------
    logic [PHASE_W-1:0] ph_t;
    logic [PHASE_W-1:0] ph_p;
    logic [PHASE_W-1:0] sh_t;
    logic [PHASE_W-1:0] sh_p;
    logic [PHASE_W-1:0] pf_t;
    logic [PHASE_W-1:0] pf_p;
    t_cordic_lane       w_cor_t [CORDIC_STAGES+1];
    t_cordic_lane       w_cor_p [CORDIC_STAGES+1];

    assign ph_t = w_div_t[DVD_W].quo;
    assign ph_p = w_div_p[DVD_W].quo;
    assign sh_t = ph_t + 32'h4000_0000;
    assign sh_p = ph_p + 32'h4000_0000;
    assign pf_t = sh_t[PHASE_W-1] ? (ph_t ^ 32'h8000_0000) : ph_t;
    assign pf_p = sh_p[PHASE_W-1] ? (ph_p ^ 32'h8000_0000) : ph_p;

    assign w_cor_t[0] = '{x: $signed(CORDIC_W'(CORDIC_GAIN)), y: '0,
                          z: $signed({{(CORDIC_W-PHASE_W){pf_t[PHASE_W-1]}}, pf_t}),
                          flip: sh_t[PHASE_W-1]};
    assign w_cor_p[0] = '{x: $signed(CORDIC_W'(CORDIC_GAIN)), y: '0,
                          z: $signed({{(CORDIC_W-PHASE_W){pf_p[PHASE_W-1]}}, pf_p}),
                          flip: sh_p[PHASE_W-1]};

    for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cordic
        swcm_cordic_cell #(.STAGE(k)) u_cor_t (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_lane (w_cor_t[k]),
            .o_lane (w_cor_t[k+1])
        );
        swcm_cordic_cell #(.STAGE(k)) u_cor_p (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_lane (w_cor_p[k]),
            .o_lane (w_cor_p[k+1])
        );
    end

    // ------------------------------------------------------------------
    // m1: undo the half-turn fold
    // ------------------------------------------------------------------
    logic signed [CORDIC_W-1:0] r_m1_st;
    logic signed [CORDIC_W-1:0] r_m1_ct;
    logic signed [CORDIC_W-1:0] r_m1_sp;
    logic signed [CORDIC_W-1:0] r_m1_cp;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m1_st <= w_cor_t[CORDIC_STAGES].flip ? -w_cor_t[CORDIC_STAGES].y
                                                   :  w_cor_t[CORDIC_STAGES].y;
            r_m1_ct <= w_cor_t[CORDIC_STAGES].flip ? -w_cor_t[CORDIC_STAGES].x
                                                   :  w_cor_t[CORDIC_STAGES].x;
            r_m1_sp <= w_cor_p[CORDIC_STAGES].flip ? -w_cor_p[CORDIC_STAGES].y
                                                   :  w_cor_p[CORDIC_STAGES].y;
            r_m1_cp <= w_cor_p[CORDIC_STAGES].flip ? -w_cor_p[CORDIC_STAGES].x
                                                   :  w_cor_p[CORDIC_STAGES].x;
        end
    end

    // ------------------------------------------------------------------
    // m2: unit ray in Q30
    // ------------------------------------------------------------------
    logic signed [2*CORDIC_W-1:0] prod_x;
    logic signed [2*CORDIC_W-1:0] prod_z;
    logic signed [CORDIC_W-1:0]   r_m2_ray [3];

    assign prod_x = r_m1_st * r_m1_cp;
    assign prod_z = r_m1_ct * r_m1_cp;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m2_ray[0] <= prod_x[FRAC +: CORDIC_W];
            r_m2_ray[1] <= r_m1_sp;
            r_m2_ray[2] <= prod_z[FRAC +: CORDIC_W];
        end
    end

    // ------------------------------------------------------------------
    // m3: nine coefficient products, m4: row sums in Q44
    // ------------------------------------------------------------------
    logic signed [PROD_W-1:0] r_m3_prod [3][3];
    logic signed [SUM_W-1:0]  r_m4_b [3];

    for (genvar r = 0; r < 3; r++) begin : g_row
        for (genvar c = 0; c < 3; c++) begin : g_col
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_m3_prod[r][c] <= $signed(r_rot[r][COEF_W*c +: COEF_W]) * r_m2_ray[c];
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_m4_b[r] <= SUM_W'(r_m3_prod[r][0]) + SUM_W'(r_m3_prod[r][1])
                           + SUM_W'(r_m3_prod[r][2]);
            end
        end
    end

    // ------------------------------------------------------------------
    // m5: behind test and magnitudes
    // ------------------------------------------------------------------
    logic [Z_W-1:0] r_m5_mag_x;
    logic [Z_W-1:0] r_m5_mag_y;
    logic [Z_W-1:0] r_m5_z;
    logic           r_m5_neg_x;
    logic           r_m5_neg_y;
    logic           r_m5_behind;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m5_neg_x  <= r_m4_b[0][SUM_W-1];
            r_m5_neg_y  <= r_m4_b[1][SUM_W-1];
            r_m5_mag_x  <= r_m4_b[0][SUM_W-1] ? Z_W'(-r_m4_b[0]) : Z_W'(r_m4_b[0]);
            r_m5_mag_y  <= r_m4_b[1][SUM_W-1] ? Z_W'(-r_m4_b[1]) : Z_W'(r_m4_b[1]);
            r_m5_z      <= Z_W'(r_m4_b[2]);
            r_m5_behind <= (r_m4_b[2] <= EPS_S);
        end
    end

    // ------------------------------------------------------------------
    // m6: scaled dividends with the half-divisor rounding term
    // ------------------------------------------------------------------
    logic [REM_W-1:0] r_m6_d_x;
    logic [REM_W-1:0] r_m6_d_y;
    logic [Z_W-1:0]   r_m6_z;
    logic             r_m6_neg_x;
    logic             r_m6_neg_y;
    logic             r_m6_behind;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m6_d_x    <= REM_W'(r_m5_mag_x) * REM_W'(r_focal) + REM_W'(r_m5_z >> 1);
            r_m6_d_y    <= REM_W'(r_m5_mag_y) * REM_W'(r_focal) + REM_W'(r_m5_z >> 1);
            r_m6_z      <= r_m5_z;
            r_m6_neg_x  <= r_m5_neg_x;
            r_m6_neg_y  <= r_m5_neg_y;
            r_m6_behind <= r_m5_behind;
        end
    end

    // ------------------------------------------------------------------
    // m7: quotient range check, anything at or above 2^23 is clipped
    // ------------------------------------------------------------------
    t_proj_lane r_m7_u;
    t_proj_lane r_m7_v;
    logic [PR_W-1:0] lim;

    assign lim = PR_W'(r_m6_z) << Q_BITS;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m7_u <= '{rem: r_m6_d_x, z: r_m6_z, q: '0,
                        ovf: (PR_W'(r_m6_d_x) >= lim), neg: r_m6_neg_x, behind: r_m6_behind};
            r_m7_v <= '{rem: r_m6_d_y, z: r_m6_z, q: '0,
                        ovf: (PR_W'(r_m6_d_y) >= lim), neg: r_m6_neg_y, behind: r_m6_behind};
        end
    end

    // ------------------------------------------------------------------
    // projection dividers, msb first
    // ------------------------------------------------------------------
    t_proj_lane w_prj_u [Q_BITS+1];
    t_proj_lane w_prj_v [Q_BITS+1];

    assign w_prj_u[0] = r_m7_u;
    assign w_prj_v[0] = r_m7_v;

    for (genvar k = 0; k < Q_BITS; k++) begin : g_proj
        swcm_proj_cell #(.BIT(Q_BITS-1-k)) u_prj_u (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_lane (w_prj_u[k]),
            .o_lane (w_prj_u[k+1])
        );
        swcm_proj_cell #(.BIT(Q_BITS-1-k)) u_prj_v (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_lane (w_prj_v[k]),
            .o_lane (w_prj_v[k+1])
        );
    end

    // ------------------------------------------------------------------
    // output stage: clip quotient, add image center, saturate
    // ------------------------------------------------------------------
    function automatic logic [OUT_W-1:0] place(
        input logic [CFG_W-1:0]  size,
        input logic [Q_BITS-1:0] q,
        input logic              ovf,
        input logic              neg
    );
        logic [Q_BITS-1:0]       qc;
        logic signed [VAL_W-1:0] base;
        logic signed [VAL_W-1:0] val;
        qc   = (ovf || q > Q_BITS'(QUOT_CLIP)) ? Q_BITS'(QUOT_CLIP) : q;
        base = $signed(VAL_W'({size, 3'b000}));
        val  = neg ? base - $signed(VAL_W'(qc)) : base + $signed(VAL_W'(qc));
        if (val > V_MAX) begin
            val = V_MAX;
        end else if (val < V_MIN) begin
            val = V_MIN;
        end
        return val[OUT_W-1:0];
    endfunction

    logic signed [OUT_W-1:0] r_src_u;
    logic signed [OUT_W-1:0] r_src_v;
    logic                    r_behind;

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (w_prj_u[Q_BITS].behind) begin
                // ray points away from the source camera
                r_src_u <= OUT_W'(OUT_MAX);
                r_src_v <= OUT_W'(OUT_MAX);
            end else begin
                r_src_u <= place(r_src_width, w_prj_u[Q_BITS].q,
                                 w_prj_u[Q_BITS].ovf, w_prj_u[Q_BITS].neg);
                r_src_v <= place(r_src_height, w_prj_v[Q_BITS].q,
                                 w_prj_v[Q_BITS].ovf, w_prj_v[Q_BITS].neg);
            end
            r_behind <= w_prj_u[Q_BITS].behind;
        end
    end

    assign o_src_u  = r_src_u;
    assign o_src_v  = r_src_v;
    assign o_behind = r_behind;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `SWCM_ASSERT_SAME(a_behind_sat, o_valid && o_behind, (o_src_u == OUT_W'(OUT_MAX)) && (o_src_v == OUT_W'(OUT_MAX)), "behind result not saturated")
    `SWCM_ASSERT_NEXT(a_hold_pipe, o_stall, $stable(r_vld), "pipe moved while stalled")
    `SWCM_ASSERT_NEXT(a_take_req, i_valid && !o_stall, r_vld[0], "accepted request not in pipe")

endmodule

@@ tb/swcm_checker.sv @@
// ----------------------------------------------------------------------------
// swcm_checker
// watches the request, result and register channels of the warp unit,
// predicts each result from its own copy of the registers and compares
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module swcm_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  logic                                o_stall,
    input  logic [swcm_pkg::PIX_W-1:0]          i_pix_x,
    input  logic [swcm_pkg::PIX_W-1:0]          i_pix_y,
    input  logic                                o_valid,
    input  logic                                i_stall,
    input  logic signed [swcm_pkg::OUT_W-1:0]   o_src_u,
    input  logic signed [swcm_pkg::OUT_W-1:0]   o_src_v,
    input  logic                                o_behind,
    input  logic                                i_cfg_valid,
    input  logic                                o_cfg_ready,
    input  logic [swcm_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [swcm_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output int                                  o_errors,
    output int                                  o_pending
);
    import swcm_pkg::*;

    typedef struct {
        logic signed [OUT_W-1:0] u;
        logic signed [OUT_W-1:0] v;
        logic                    behind;
    } t_warp;

    t_warp coord_q[$];

    logic [CFG_W-1:0]   dst_w, dst_h, src_w, src_h;
    logic [FOCAL_W-1:0] focal;
    logic [ROW_W-1:0]   row0, row1, row2;

    // rounded phase in 2^-32 turn
    function automatic logic [31:0] turn_phase(longint unsigned num, longint unsigned den);
        longint unsigned q;
        q = ((num << 32) + den / 2) / den;
        return q[31:0];
    endfunction

    // rotation-mode cordic after a half-turn fold
    function automatic void sin_cos(logic [31:0] p, output longint s, output longint c);
        logic   flip;
        logic [31:0] t;
        longint x, y, z, dx, dy;
        t = p + 32'h4000_0000;
        flip = t[31];
        if (flip) p = p ^ 32'h8000_0000;
        z = longint'($signed(p));
        x = longint'(CORDIC_GAIN);
        y = 0;
        for (int i = 0; i < CORDIC_STAGES_DEF; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= longint'(ATAN_TURNS[i]);
            end else begin
                x += dx; y -= dy; z += longint'(ATAN_TURNS[i]);
            end
        end
        if (flip) begin
            x = -x; y = -y;
        end
        s = y;
        c = x;
    endfunction

    function automatic longint dot_row(logic [ROW_W-1:0] r, longint a, longint b, longint c);
        shortint k0, k1, k2;
        k0 = r[15:0];
        k1 = r[31:16];
        k2 = r[47:32];
        return longint'(k0) * a + longint'(k1) * b + longint'(k2) * c;
    endfunction

    function automatic logic signed [OUT_W-1:0] plane_coord(longint num, longint z,
                                                           longint unsigned size);
        longint unsigned mag, q;
        longint val;
        mag = (num < 0) ? longint'(-num) : num;
        q = (mag * longint'(focal) + longint'(z) / 2) / longint'(z);
        if (q > QUOT_CLIP) q = QUOT_CLIP;
        val = longint'(size * 8) + ((num < 0) ? -longint'(q) : longint'(q));
        if (val > OUT_MAX) val = OUT_MAX;
        if (val < OUT_MIN) val = OUT_MIN;
        return val[OUT_W-1:0];
    endfunction

    function automatic t_warp map_coord(logic [PIX_W-1:0] px, logic [PIX_W-1:0] py);
        longint unsigned x, y, w, h;
        longint st, ct, sp, cp, rx, ry, rz, bx, by, bz;
        t_warp r;
        x = px;
        y = py;
        w = (dst_w == 0) ? 1 : dst_w;
        h = (dst_h == 0) ? 1 : dst_h;
        sin_cos(turn_phase(2 * x + w, 2 * w), st, ct);
        sin_cos(turn_phase(2 * y + 3 * h, 4 * h), sp, cp);
        rx = (st * cp) >>> 30;
        ry = sp;
        rz = (ct * cp) >>> 30;
        bx = dot_row(row0, rx, ry, rz);
        by = dot_row(row1, rx, ry, rz);
        bz = dot_row(row2, rx, ry, rz);
        if (bz <= EPS_Q44) begin
            r.behind = 1'b1;
            r.u = OUT_MAX;
            r.v = OUT_MAX;
        end else begin
            r.behind = 1'b0;
            r.u = plane_coord(bx, bz, src_w);
            r.v = plane_coord(by, bz, src_h);
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_warp want;
        if (!i_rst_n) begin
            dst_w <= RST_DST_WIDTH;
            dst_h <= RST_DST_HEIGHT;
            src_w <= RST_SRC_WIDTH;
            src_h <= RST_SRC_HEIGHT;
            focal <= RST_FOCAL;
            row0  <= RST_ROT_ROW0;
            row1  <= RST_ROT_ROW1;
            row2  <= RST_ROT_ROW2;
            coord_q.delete();
            o_errors  = 0;
            o_pending = 0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_DST_WIDTH:  dst_w <= i_cfg_data[CFG_W-1:0];
                    REG_DST_HEIGHT: dst_h <= i_cfg_data[CFG_W-1:0];
                    REG_SRC_WIDTH:  src_w <= i_cfg_data[CFG_W-1:0];
                    REG_SRC_HEIGHT: src_h <= i_cfg_data[CFG_W-1:0];
                    REG_FOCAL:      focal <= i_cfg_data[FOCAL_W-1:0];
                    REG_ROT_ROW0:   row0  <= i_cfg_data[ROW_W-1:0];
                    REG_ROT_ROW1:   row1  <= i_cfg_data[ROW_W-1:0];
                    REG_ROT_ROW2:   row2  <= i_cfg_data[ROW_W-1:0];
                    default: ;
                endcase
            end
            if (i_valid && !o_stall)
                coord_q.push_back(map_coord(i_pix_x, i_pix_y));
            if (o_valid && !i_stall) begin
                if (coord_q.size() == 0) begin
                    $error("result with no request outstanding");
                    o_errors++;
                end else begin
                    want = coord_q.pop_front();
                    if (o_src_u !== want.u) begin
                        $error("src_u expected %0d actual %0d", want.u, o_src_u);
                        o_errors++;
                    end
                    if (o_src_v !== want.v) begin
                        $error("src_v expected %0d actual %0d", want.v, o_src_v);
                        o_errors++;
                    end
                    if (o_behind !== want.behind) begin
                        $error("behind expected %0d actual %0d", want.behind, o_behind);
                        o_errors++;
                    end
                end
            end
            o_pending = coord_q.size();
        end
    end

endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// drives the warp unit with directed and random pixel requests over several
// register settings, with random stalls on both sides; checking is done by
// the checker instance, this module gives the verdict
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import swcm_pkg::*;

    localparam int IDLE_LIMIT = 5000;   // cycles with no handshake at all
    localparam int DRAIN      = 150;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_valid;
    logic                    o_stall;
    logic [PIX_W-1:0]        i_pix_x;
    logic [PIX_W-1:0]        i_pix_y;
    logic                    o_valid;
    logic                    i_stall;
    logic signed [OUT_W-1:0] o_src_u;
    logic signed [OUT_W-1:0] o_src_v;
    logic                    o_behind;
    logic                    i_cfg_valid;
    logic                    o_cfg_ready;
    logic [CFG_IDX_W-1:0]    i_cfg_index;
    logic [CFG_DATA_W-1:0]   i_cfg_data;

    int errors;
    int pending;
    int idle_cycles;
    int stall_left;
    bit stall_now;
    bit calm;        // final stretch runs with no idling
    int span_w, span_h;

    spherical_warp_coordinate_map_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_pix_x     (i_pix_x),
        .i_pix_y     (i_pix_y),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_src_u     (o_src_u),
        .o_src_v     (o_src_v),
        .o_behind    (o_behind),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    swcm_checker u_chk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_pix_x     (i_pix_x),
        .i_pix_y     (i_pix_y),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_src_u     (o_src_u),
        .o_src_v     (o_src_v),
        .o_behind    (o_behind),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // result side back-pressure: stalled bursts of random length between free runs
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stall_left <= 0;
            i_stall    <= 1'b0;
        end else if (stall_left == 0) begin
            stall_now = calm ? 1'b0 : ($urandom_range(0, 3) == 0);
            stall_left <= stall_now ? $urandom_range(1, 8) : $urandom_range(1, 16);
            i_stall    <= stall_now;
        end else begin
            stall_left <= stall_left - 1;
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)
            || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // three Q2.14 coefficients, column 0 in the low bits
    function automatic logic [ROW_W-1:0] pack_row(int c0, int c1, int c2);
        logic [15:0] a, b, c;
        a = 16'(c0);
        b = 16'(c1);
        c = 16'(c2);
        return {c, b, a};
    endfunction

    function automatic logic [ROW_W-1:0] near_unit_row(int col);
        int c [3];
        for (int k = 0; k < 3; k++)
            c[k] = (k == col) ? 16384 - $urandom_range(0, 3000) : $urandom_range(0, 6000) - 3000;
        return pack_row(c[0], c[1], c[2]);
    endfunction

    task automatic send_pixel(logic [PIX_W-1:0] x, logic [PIX_W-1:0] y);
        if (!calm && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_pix_x <= x;
        i_pix_y <= y;
        do @(posedge i_clk); while (o_stall);
    endtask

    // all requests out of the pipe, then a margin for the pipe itself
    task automatic wait_drained();
        i_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_sizes(int dw, int dh, int sw, int sh, int f);
        write_reg(REG_DST_WIDTH, CFG_DATA_W'(dw));
        write_reg(REG_DST_HEIGHT, CFG_DATA_W'(dh));
        write_reg(REG_SRC_WIDTH, CFG_DATA_W'(sw));
        write_reg(REG_SRC_HEIGHT, CFG_DATA_W'(sh));
        write_reg(REG_FOCAL, CFG_DATA_W'(f));
        span_w = (dw == 0) ? 1 : dw;
        span_h = (dh == 0) ? 1 : dh;
    endtask

    // mostly inside the image, a quarter over the whole 12-bit field
    task automatic send_random(int n);
        logic [PIX_W-1:0] x, y;
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 3) == 0 || span_w > 4096) x = PIX_W'($urandom_range(0, 4095));
            else x = PIX_W'($urandom_range(0, span_w - 1));
            if ($urandom_range(0, 3) == 0 || span_h > 4096) y = PIX_W'($urandom_range(0, 4095));
            else y = PIX_W'($urandom_range(0, span_h - 1));
            send_pixel(x, y);
        end
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_pix_x     = '0;
        i_pix_y     = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        calm        = 1'b0;
        span_w      = 1024;
        span_h      = 512;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: corners, center, poles, theta at +-pi and +pi/2
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd4095);
        send_pixel(12'd512, 12'd256);
        send_pixel(12'd0, 12'd256);
        send_pixel(12'd768, 12'd256);
        send_pixel(12'd1024, 12'd256);
        send_pixel(12'd2048, 12'd300);
        send_pixel(12'd512, 12'd0);
        send_pixel(12'd512, 12'd511);
        send_pixel(12'd600, 12'd4095);
        send_random(140);
        wait_drained();

        // sizes of 4096, largest focal length, identity
        write_sizes(4096, 4096, 4096, 4096, 65535);
        write_reg(REG_ROT_ROW0, RST_ROT_ROW0);
        write_reg(REG_ROT_ROW1, RST_ROT_ROW1);
        write_reg(REG_ROT_ROW2, RST_ROT_ROW2);
        send_pixel(12'd2048, 12'd2048);
        send_pixel(12'd2800, 12'd2048);
        send_pixel(12'd2048, 12'd2900);
        send_pixel(12'd1030, 12'd1030);
        send_random(140);
        wait_drained();

        // sizes of one, focal length 16, extreme coefficients, stray indexes
        write_sizes(1, 1, 1, 1, 16);
        write_reg(REG_ROT_ROW0, pack_row(32767, -32768, 0));
        write_reg(REG_ROT_ROW1, pack_row(-32768, 32767, -32768));
        write_reg(REG_ROT_ROW2, pack_row(0, 0, 32767));
        write_reg(4'd8, 48'hFFFF_FFFF_FFFF);
        write_reg(4'd15, 48'h0);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd0);
        send_random(140);
        wait_drained();

        // zero sizes act as one, raw random rotation
        write_sizes(0, 0, $urandom_range(0, 8191), $urandom_range(0, 8191),
                    $urandom_range(16, 65535));
        write_reg(REG_ROT_ROW0, CFG_DATA_W'({$urandom, $urandom}));
        write_reg(REG_ROT_ROW1, CFG_DATA_W'({$urandom, $urandom}));
        write_reg(REG_ROT_ROW2, CFG_DATA_W'({$urandom, $urandom}));
        send_random(120);
        wait_drained();

        // near-identity rotations with random sizes; one full pause midway
        for (int ph = 0; ph < 3; ph++) begin
            if (ph == 2) calm = 1'b1;
            write_sizes($urandom_range(1, 4096), $urandom_range(1, 4096),
                        $urandom_range(1, 4096), $urandom_range(1, 4096),
                        $urandom_range(16, 65535));
            write_reg(REG_ROT_ROW0, near_unit_row(0));
            write_reg(REG_ROT_ROW1, near_unit_row(1));
            write_reg(REG_ROT_ROW2, near_unit_row(2));
            send_random(80);
            if (ph == 0) begin
                i_valid <= 1'b0;
                while (pending != 0) @(posedge i_clk);
            end
            send_random(80);
            wait_drained();
        end

        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
